>>> rtl/core/rotary_position_rotate_assert.svh
// Assertion macros for the rotary position rotate block
`ifndef ROTARY_POSITION_ROTATE_ASSERT_SVH
`define ROTARY_POSITION_ROTATE_ASSERT_SVH

// Checked outside reset only
`define RPR_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define RPR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/rpr_pkg.sv
// Shared types, constants and helpers for the rotary position rotate block
`timescale 1ns / 1ps

package rpr_pkg;

    localparam int VALUE_W  = 16;
    localparam int TABLE_W  = 16;
    localparam int ADDR_W   = 14;
    localparam int TPOS_W   = 13;
    localparam int PAIR_W   = 7;
    localparam int HEAD_W   = 6;
    localparam int POS_W    = 12;
    localparam int PPH_W    = 8;
    localparam int IDX_W    = TPOS_W + PPH_W + 1;
    localparam int PROD_W   = VALUE_W + TABLE_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int FRAC_SH  = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHAPE = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    localparam logic REQ_TABLE_WRITE = 1'b0;
    localparam logic REQ_ROTATE      = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEQUENCE_LENGTH = 3'd0,
        CFG_HEAD_COUNT      = 3'd1,
        CFG_PAIRS_PER_HEAD  = 3'd2,
        CFG_TABLE_POSITIONS = 3'd3,
        CFG_POSITION_OFFSET = 3'd4,
        CFG_ROTATE_BACKWARD = 3'd5
    } rpr_cfg_idx_t;

    typedef struct packed {
        logic                       req_type;
        logic                       start_of_tensor;
        logic [ADDR_W-1:0]          table_address;
        logic signed [TABLE_W-1:0]  table_cosine;
        logic signed [TABLE_W-1:0]  table_sine;
        logic signed [VALUE_W-1:0]  first_value;
        logic signed [VALUE_W-1:0]  second_value;
    } rpr_in_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [VALUE_W-1:0]  out_first;
        logic signed [VALUE_W-1:0]  out_second;
    } rpr_out_t;

    // One classified item between front and back
    typedef struct packed {
        logic                       is_rotate;
        logic                       pos_oor;
        logic [TPOS_W-1:0]          tpos;
        logic [PAIR_W-1:0]          pair;
        logic [ADDR_W-1:0]          table_address;
        logic signed [TABLE_W-1:0]  table_cosine;
        logic signed [TABLE_W-1:0]  table_sine;
        logic signed [VALUE_W-1:0]  first_value;
        logic signed [VALUE_W-1:0]  second_value;
    } rpr_entry_t;

    typedef struct packed {
        logic                       full;
        logic                       empty;
        logic [QCNT_W-1:0]          count;
    } rpr_qstat_t;

    // Settings the back end needs
    typedef struct packed {
        logic [PPH_W-1:0]           pair_span;
        logic                       backward;
    } rpr_bcfg_t;

    typedef struct packed {
        logic                       sat;
        logic signed [VALUE_W-1:0]  value;
    } rpr_rnd_t;

    // Round Q.26 to Q3.12 (half up, floor) and saturate
    function automatic rpr_rnd_t rpr_round_sat(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0]          t;
        logic signed [SUM_W-FRAC_SH-1:0]  r;
        logic signed [SUM_W-FRAC_SH-1:0]  hi;
        logic signed [SUM_W-FRAC_SH-1:0]  lo;
        rpr_rnd_t                         res;
        t  = x + SUM_W'(signed'(1 << (FRAC_SH - 1)));
        r  = (SUM_W-FRAC_SH)'(t >>> FRAC_SH);
        hi = (SUM_W-FRAC_SH)'((1 << (VALUE_W - 1)) - 1);
        lo = -hi - (SUM_W-FRAC_SH)'(1);
        if (r > hi)
        begin
            res.sat   = 1'b1;
            res.value = hi[VALUE_W-1:0];
        end
        else if (r < lo)
        begin
            res.sat   = 1'b1;
            res.value = lo[VALUE_W-1:0];
        end
        else
        begin
            res.sat   = 1'b0;
            res.value = r[VALUE_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/core/rpr_front.sv
// Front end: configuration registers, pair/head/position counters, item classification
`timescale 1ns / 1ps

module rpr_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  rpr_pkg::rpr_in_t                  req,
    input  logic                              cfg_we,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  rpr_pkg::rpr_qstat_t               qstat,
    output logic                              push,
    output rpr_pkg::rpr_entry_t               entry,
    output rpr_pkg::rpr_bcfg_t                bcfg
);
    import rpr_pkg::*;

    logic [TPOS_W-1:0]  seq_len_reg;
    logic [PAIR_W-1:0]  head_cnt_cfg_reg;
    logic [PPH_W-1:0]   pph_reg;
    logic [TPOS_W-1:0]  tab_pos_reg;
    logic [POS_W-1:0]   offset_reg;
    logic               backward_reg;

    logic [PAIR_W-1:0]  pair_reg, pair_next;
    logic [HEAD_W-1:0]  head_reg, head_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic [PPH_W-1:0]   pph_eff;
    logic [PAIR_W-1:0]  hc_eff;
    logic [TPOS_W-1:0]  sl_eff;
    logic [PAIR_W-1:0]  pair_cur;
    logic [HEAD_W-1:0]  head_cur;
    logic [POS_W-1:0]   pos_cur;
    logic [PPH_W-1:0]   pair_inc;
    logic [PAIR_W-1:0]  head_inc;
    logic [TPOS_W-1:0]  pos_inc;
    logic [TPOS_W-1:0]  tpos;
    logic               rot_xfer;

    always_comb
    begin
        pph_eff = (pph_reg == '0) ? PPH_W'(1)
                : ((pph_reg > PPH_W'(128)) ? PPH_W'(128) : pph_reg);
        hc_eff  = (head_cnt_cfg_reg == '0) ? PAIR_W'(1)
                : ((head_cnt_cfg_reg > PAIR_W'(64)) ? PAIR_W'(64) : head_cnt_cfg_reg);
        sl_eff  = (seq_len_reg == '0) ? TPOS_W'(1)
                : ((seq_len_reg > TPOS_W'(4096)) ? TPOS_W'(4096) : seq_len_reg);
    end

    assign req_ready = !qstat.full;
    assign push      = req_valid && req_ready;
    assign rot_xfer  = push && (req.req_type == REQ_ROTATE);

    always_comb
    begin
        pair_cur = req.start_of_tensor ? '0 : pair_reg;
        head_cur = req.start_of_tensor ? '0 : head_reg;
        pos_cur  = req.start_of_tensor ? '0 : pos_reg;
        tpos     = TPOS_W'(offset_reg) + TPOS_W'(pos_cur);
        pair_inc = PPH_W'(pair_cur) + PPH_W'(1);
        head_inc = PAIR_W'(head_cur) + PAIR_W'(1);
        pos_inc  = TPOS_W'(pos_cur) + TPOS_W'(1);
        pair_next = pair_inc[PAIR_W-1:0];
        head_next = head_cur;
        pos_next  = pos_cur;
        if (pair_inc >= pph_eff)
        begin
            pair_next = '0;
            head_next = head_inc[HEAD_W-1:0];
            if (head_inc >= hc_eff)
            begin
                head_next = '0;
                pos_next  = (pos_inc >= sl_eff) ? '0 : pos_inc[POS_W-1:0];
            end
        end
    end

    always_comb
    begin
        entry.is_rotate     = (req.req_type == REQ_ROTATE);
        entry.pos_oor       = (tpos >= tab_pos_reg);
        entry.tpos          = tpos;
        entry.pair          = pair_cur;
        entry.table_address = req.table_address;
        entry.table_cosine  = req.table_cosine;
        entry.table_sine    = req.table_sine;
        entry.first_value   = req.first_value;
        entry.second_value  = req.second_value;
    end

    assign bcfg.pair_span = pph_eff;
    assign bcfg.backward  = backward_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg      <= TPOS_W'(1);
            head_cnt_cfg_reg <= PAIR_W'(1);
            pph_reg          <= PPH_W'(1);
            tab_pos_reg      <= TPOS_W'(1);
            offset_reg       <= '0;
            backward_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEQUENCE_LENGTH: seq_len_reg      <= cfg_wdata;
                CFG_HEAD_COUNT:      head_cnt_cfg_reg <= cfg_wdata[PAIR_W-1:0];
                CFG_PAIRS_PER_HEAD:  pph_reg          <= cfg_wdata[PPH_W-1:0];
                CFG_TABLE_POSITIONS: tab_pos_reg      <= cfg_wdata;
                CFG_POSITION_OFFSET: offset_reg       <= cfg_wdata[POS_W-1:0];
                CFG_ROTATE_BACKWARD: backward_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg <= '0;
            head_reg <= '0;
            pos_reg  <= '0;
        end
        else if (rot_xfer)
        begin
            pair_reg <= pair_next;
            head_reg <= head_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

>>> rtl/core/rpr_queue.sv
// Short FIFO between the front and back ends
`timescale 1ns / 1ps

module rpr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rpr_pkg::rpr_entry_t   wr_entry,
    input  logic                  pop,
    output rpr_pkg::rpr_entry_t   rd_entry,
    output rpr_pkg::rpr_qstat_t   qstat
);
    import rpr_pkg::*;

    rpr_entry_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign qstat.count = count_reg;
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign rd_entry    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_next;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/rpr_back.sv
// Back end: table stores, index multiply, rotation products, rounding and output register
`timescale 1ns / 1ps

module rpr_back #(
    parameter int TABLE_DEPTH = 16384
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rpr_pkg::rpr_entry_t   head,
    input  rpr_pkg::rpr_qstat_t   qstat,
    input  rpr_pkg::rpr_bcfg_t    bcfg,
    output logic                  pop,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rpr_pkg::rpr_out_t     rsp
);
    import rpr_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [TABLE_W-1:0]          cos_mem [TABLE_DEPTH];
    logic [TABLE_W-1:0]          sin_mem [TABLE_DEPTH];

    logic                        adv;
    logic                        a_valid;
    logic [IDX_W-1:0]            tidx;
    logic                        a_err;
    logic                        wr_ok;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;

    logic                        b_valid_reg;
    logic                        b_rot_reg;
    logic                        b_err_reg;
    logic signed [VALUE_W-1:0]   b_first_reg;
    logic signed [VALUE_W-1:0]   b_second_reg;
    logic signed [TABLE_W-1:0]   cos_rd_reg;
    logic signed [TABLE_W-1:0]   sin_rd_reg;

    logic                        c_valid_reg;
    logic                        c_rot_reg;
    logic                        c_err_reg;
    logic signed [PROD_W-1:0]    p_ac_reg;
    logic signed [PROD_W-1:0]    p_bs_reg;
    logic signed [PROD_W-1:0]    p_as_reg;
    logic signed [PROD_W-1:0]    p_bc_reg;

    logic signed [SUM_W-1:0]     sum1;
    logic signed [SUM_W-1:0]     sum2;
    rpr_rnd_t                    rnd1;
    rpr_rnd_t                    rnd2;

    logic                        rsp_valid_reg, rsp_valid_next;
    rpr_out_t                    rsp_reg, rsp_next;

    assign adv     = !rsp_valid_reg || rsp_ready;
    assign a_valid = !qstat.empty;
    assign pop     = adv && a_valid;

    always_comb
    begin
        tidx    = IDX_W'(head.tpos) * IDX_W'(bcfg.pair_span) + IDX_W'(head.pair);
        a_err   = head.pos_oor || (tidx >= IDX_W'(TABLE_DEPTH));
        rd_addr = AW'(tidx);
        wr_ok   = (32'(head.table_address) < 32'(TABLE_DEPTH));
        wr_addr = AW'({{AW{1'b0}}, head.table_address});
    end

    always_ff @(posedge clk)
    begin
        if (pop && !head.is_rotate && wr_ok)
        begin
            cos_mem[wr_addr] <= head.table_cosine;
            sin_mem[wr_addr] <= head.table_sine;
        end
        if (pop && head.is_rotate)
        begin
            cos_rd_reg <= cos_mem[rd_addr];
            sin_rd_reg <= sin_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_err_reg    <= a_err;
            b_first_reg  <= head.first_value;
            b_second_reg <= head.second_value;
            c_err_reg    <= b_err_reg;
            p_ac_reg     <= b_first_reg * cos_rd_reg;
            p_bs_reg     <= b_second_reg * sin_rd_reg;
            p_as_reg     <= b_first_reg * sin_rd_reg;
            p_bc_reg     <= b_second_reg * cos_rd_reg;
        end
    end

    always_comb
    begin
        if (!bcfg.backward)
        begin
            sum1 = SUM_W'(p_ac_reg) - SUM_W'(p_bs_reg);
            sum2 = SUM_W'(p_as_reg) + SUM_W'(p_bc_reg);
        end
        else
        begin
            sum1 = SUM_W'(p_ac_reg) + SUM_W'(p_bs_reg);
            sum2 = SUM_W'(p_bc_reg) - SUM_W'(p_as_reg);
        end
        rnd1 = rpr_round_sat(sum1);
        rnd2 = rpr_round_sat(sum2);
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (adv)
        begin
            rsp_valid_next = c_valid_reg && c_rot_reg;
            if (c_err_reg)
            begin
                rsp_next.status     = STATUS_SHAPE;
                rsp_next.out_first  = '0;
                rsp_next.out_second = '0;
            end
            else
            begin
                rsp_next.status     = (rnd1.sat || rnd2.sat) ? STATUS_SAT : STATUS_OK;
                rsp_next.out_first  = rnd1.value;
                rsp_next.out_second = rnd2.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            b_rot_reg     <= 1'b0;
            c_valid_reg   <= 1'b0;
            c_rot_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                b_valid_reg <= a_valid;
                b_rot_reg   <= head.is_rotate;
                c_valid_reg <= b_valid_reg;
                c_rot_reg   <= b_rot_reg;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> rtl/core/rotary_position_rotate.sv
// A rotate transfer passes the queue, the table read, the product registers and the output register.
// Throughput: one item per cycle without output stalls (single-port table read, pipelined multipliers).
// Table-write items give no result; a 4-entry queue lets the front keep taking items during stalls.
// Reset: rst_n asynchronous, active low; clears counters, queue and valid flags, loads the
// default configuration. Table stores are not cleared and hold nothing valid until written.
`timescale 1ns / 1ps
`include "rotary_position_rotate_assert.svh"

module rotary_position_rotate #(
    parameter int TABLE_DEPTH = 16384
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  rpr_pkg::rpr_in_t                  req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output rpr_pkg::rpr_out_t                 rsp,
    input  logic                              cfg_we,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import rpr_pkg::*;

    logic        q_push;
    logic        q_pop;
    rpr_entry_t  q_wr_entry;
    rpr_entry_t  q_head;
    rpr_qstat_t  q_stat;
    rpr_bcfg_t   bcfg;

    rpr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .qstat     (q_stat),
        .push      (q_push),
        .entry     (q_wr_entry),
        .bcfg      (bcfg)
    );

    rpr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .rd_entry (q_head),
        .qstat    (q_stat)
    );

    rpr_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .qstat     (q_stat),
        .bcfg      (bcfg),
        .pop       (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    `RPR_ASSERT_ALWAYS(a_no_rsp_in_reset, !rst_n ##1 !rst_n |=> !rsp_valid, "result valid during reset")
    `RPR_ASSERT_RUN(a_full_blocks_req, q_stat.full |-> !req_ready, "request taken with queue full")
    `RPR_ASSERT_RUN(a_qcount_bound, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
    `RPR_ASSERT_RUN(a_pop_not_empty, q_pop |-> !q_stat.empty, "pop from empty queue")

endmodule

>>> dv/tb_rotary_position_rotate.sv
// Self-checking testbench for rotary_position_rotate: directed and random pair rotation
`timescale 1ns / 1ps

module tb_rotary_position_rotate;

    import rpr_pkg::*;

    localparam int TABLE_ENTRIES = 16384;
    localparam int IDLE_LIMIT    = 1000;
    localparam int RANDOM_ITEMS  = 1100;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    rpr_in_t               req = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rpr_out_t              rsp;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Register copies, reset values
    int cfg_seq_len  = 1;
    int cfg_heads    = 1;
    int cfg_pairs    = 1;
    int cfg_rows     = 1;
    int cfg_offset   = 0;
    int cfg_backward = 0;

    logic [15:0] cos_copy [TABLE_ENTRIES];
    logic [15:0] sin_copy [TABLE_ENTRIES];
    int pair_ctr = 0;
    int head_ctr = 0;
    int pos_ctr  = 0;

    rpr_in_t  queued_requests [$];
    rpr_out_t expected_pairs [$];
    bit       entry_loaded [TABLE_ENTRIES];
    int       reach_list [$];
    int       requests_queued = 0;
    int       mismatches = 0;
    int       send_gap = 0;
    int       stall_left = 0;
    int       idle_cycles = 0;
    bit       calm_sender = 1'b0;
    bit       calm_receiver = 1'b0;

    rotary_position_rotate i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int clamp_geometry(input int v, input int cap);
        if (v == 0)
            return 1;
        return (v > cap) ? cap : v;
    endfunction

    function automatic int pick_idle(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_value();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return int'($urandom_range(0, 16)) - 8;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int pick_trig();
        case ($urandom_range(0, 9))
            0: return -16384;
            1: return 16384;
            2: return 0;
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    function automatic int pick_geometry(input int low_max, input int cap, input int all_ones);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return cap;
            2: return all_ones;
            3: return $urandom_range(0, all_ones);
            default: return $urandom_range(1, low_max);
        endcase
    endfunction

    function automatic void queue_request(input logic kind, input logic start, input int addr,
                                          input int cos_v, input int sin_v,
                                          input int first, input int second);
        rpr_in_t item;
        item.req_type        = kind;
        item.start_of_tensor = start;
        item.table_address   = ADDR_W'(addr);
        item.table_cosine    = TABLE_W'(cos_v);
        item.table_sine      = TABLE_W'(sin_v);
        item.first_value     = VALUE_W'(first);
        item.second_value    = VALUE_W'(second);
        if (kind == REQ_TABLE_WRITE)
            entry_loaded[item.table_address] = 1'b1;
        queued_requests.push_back(item);
        requests_queued++;
    endfunction

    function automatic logic [15:0] round_q12(input longint sum, inout bit sat);
        longint q;
        q = (sum + 64'sd8192) >>> 14;
        if (q > 32767)
        begin
            sat = 1'b1;
            q   = 32767;
        end
        else if (q < -32768)
        begin
            sat = 1'b1;
            q   = -32768;
        end
        return q[15:0];
    endfunction

    function automatic void predict_rotation(input rpr_in_t item);
        int       pairs;
        int       heads;
        int       positions;
        int       row;
        int       idx;
        longint   a;
        longint   b;
        longint   c;
        longint   s;
        bit       sat;
        rpr_out_t res;
        pairs     = clamp_geometry(cfg_pairs, 128);
        heads     = clamp_geometry(cfg_heads, 64);
        positions = clamp_geometry(cfg_seq_len, 4096);
        if (item.req_type == REQ_TABLE_WRITE)
        begin
            cos_copy[item.table_address] = item.table_cosine;
            sin_copy[item.table_address] = item.table_sine;
            return;
        end
        if (item.start_of_tensor)
        begin
            pair_ctr = 0;
            head_ctr = 0;
            pos_ctr  = 0;
        end
        row = cfg_offset + pos_ctr;
        idx = row * pairs + pair_ctr;
        res = '0;
        sat = 1'b0;
        if (row >= cfg_rows || idx >= TABLE_ENTRIES)
            res.status = STATUS_SHAPE;
        else
        begin
            a = $signed(item.first_value);
            b = $signed(item.second_value);
            c = $signed(cos_copy[idx]);
            s = $signed(sin_copy[idx]);
            if (cfg_backward == 0)
            begin
                res.out_first  = round_q12(a * c - b * s, sat);
                res.out_second = round_q12(a * s + b * c, sat);
            end
            else
            begin
                res.out_first  = round_q12(a * c + b * s, sat);
                res.out_second = round_q12(b * c - a * s, sat);
            end
            res.status = sat ? STATUS_SAT : STATUS_OK;
        end
        pair_ctr++;
        if (pair_ctr >= pairs)
        begin
            pair_ctr = 0;
            head_ctr++;
            if (head_ctr >= heads)
            begin
                head_ctr = 0;
                pos_ctr++;
                if (pos_ctr >= positions)
                    pos_ctr = 0;
            end
        end
        expected_pairs.push_back(res);
    endfunction

    // Table entries that rotations can read under the given geometry
    function automatic void collect_reachable(input int sl, input int pph, input int tp,
                                              input int off);
        int positions;
        int pairs;
        int row;
        positions = clamp_geometry(sl, 4096);
        pairs     = clamp_geometry(pph, 128);
        reach_list.delete();
        for (int p = 0; p < positions && reach_list.size() <= 200; p++)
        begin
            row = off + p;
            if (row >= tp || row * pairs >= TABLE_ENTRIES)
                break;
            for (int k = 0; k < pairs; k++)
                if (row * pairs + k < TABLE_ENTRIES)
                    reach_list.push_back(row * pairs + k);
        end
    endfunction

    task automatic wait_drain();
        do
            @(negedge clk);
        while (queued_requests.size() != 0 || req_valid || expected_pairs.size() != 0);
    endtask

    task automatic write_setting(input rpr_cfg_idx_t idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        case (idx)
            CFG_SEQUENCE_LENGTH: cfg_seq_len  = value & 32'h1FFF;
            CFG_HEAD_COUNT:      cfg_heads    = value & 32'h7F;
            CFG_PAIRS_PER_HEAD:  cfg_pairs    = value & 32'hFF;
            CFG_TABLE_POSITIONS: cfg_rows     = value & 32'h1FFF;
            CFG_POSITION_OFFSET: cfg_offset   = value & 32'hFFF;
            CFG_ROTATE_BACKWARD: cfg_backward = value & 32'h1;
            default: ;
        endcase
    endtask

    // Reconfigure once idle, then load any reachable entry not yet written
    task automatic enter_phase(input int sl, input int hc, input int pph, input int tp,
                               input int off, input int bwd);
        collect_reachable(sl, pph, tp, off);
        wait_drain();
        repeat (12) @(posedge clk);
        write_setting(CFG_SEQUENCE_LENGTH, sl);
        write_setting(CFG_HEAD_COUNT, hc);
        write_setting(CFG_PAIRS_PER_HEAD, pph);
        write_setting(CFG_TABLE_POSITIONS, tp);
        write_setting(CFG_POSITION_OFFSET, off);
        write_setting(CFG_ROTATE_BACKWARD, bwd);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        calm_sender   = ($urandom_range(0, 4) == 0);
        calm_receiver = ($urandom_range(0, 4) == 0);
        foreach (reach_list[i])
            if (!entry_loaded[reach_list[i]])
                queue_request(REQ_TABLE_WRITE, $urandom_range(0, 1), reach_list[i],
                              pick_trig(), pick_trig(), pick_value(), pick_value());
    endtask

    task automatic run_rotations(input bit pause_midway);
        int rotations;
        int addr;
        rotations = $urandom_range(40, 100);
        for (int n = 0; n < rotations; n++)
        begin
            if (pause_midway && n == rotations / 2)
                wait_drain();
            if ($urandom_range(0, 6) == 0)
            begin
                if (reach_list.size() != 0 && $urandom_range(0, 1) == 0)
                    addr = reach_list[$urandom_range(0, reach_list.size() - 1)];
                else
                    addr = $urandom_range(0, TABLE_ENTRIES - 1);
                queue_request(REQ_TABLE_WRITE, $urandom_range(0, 1), addr,
                              pick_trig(), pick_trig(), pick_value(), pick_value());
            end
            queue_request(REQ_ROTATE, (n == 0) || ($urandom_range(0, 19) == 0),
                          $urandom_range(0, TABLE_ENTRIES - 1), pick_trig(), pick_trig(),
                          pick_value(), pick_value());
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            send_gap  <= 0;
        end
        else
        begin
            if (req_valid && req_ready)
                predict_rotation(req);
            if (!req_valid || req_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap  <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (queued_requests.size() != 0)
                begin
                    req       <= queued_requests.pop_front();
                    req_valid <= 1'b1;
                    send_gap  <= pick_idle(calm_sender);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Response back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready  <= (stall_left == 1);
        end
        else
        begin
            n = pick_idle(calm_receiver);
            stall_left <= n;
            rsp_ready  <= (n == 0);
        end
    end

    // Response monitor
    always @(posedge clk)
    begin
        rpr_out_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_pairs.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected transfer, expected none, actual %0d %0d %0d", $time,
                         rsp.status, $signed(rsp.out_first), $signed(rsp.out_second));
            end
            else
            begin
                want = expected_pairs.pop_front();
                compare_field("status", want.status, rsp.status);
                compare_field("out_first", $signed(want.out_first), $signed(rsp.out_first));
                compare_field("out_second", $signed(want.out_second), $signed(rsp.out_second));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        int sl;
        int hc;
        int pph;
        int tp;
        int off;
        int bwd;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset geometry: every rotation reads entry 0
        queue_request(REQ_TABLE_WRITE, 1, 0, 16384, 0, -32768, 32767);
        queue_request(REQ_ROTATE, 1, 16383, -16384, 16384, 32767, -32768);
        queue_request(REQ_ROTATE, 0, 0, 0, 0, -32768, 32767);
        queue_request(REQ_TABLE_WRITE, 0, 0, -16384, 16384, 0, 0);
        queue_request(REQ_ROTATE, 0, 0, 0, 0, -32768, -32768);
        queue_request(REQ_ROTATE, 1, 0, 0, 0, 32767, 32767);
        queue_request(REQ_TABLE_WRITE, 0, 16383, -16384, 16384, 32767, -32768);
        queue_request(REQ_TABLE_WRITE, 1, 10922, 16384, -16384, 0, 0);
        queue_request(REQ_TABLE_WRITE, 0, 5461, 0, 0, 0, 0);
        queue_request(REQ_TABLE_WRITE, 0, 0, 11585, -11585, 0, 0);
        queue_request(REQ_ROTATE, 0, 0, 0, 0, 1, -1);
        queue_request(REQ_ROTATE, 0, 0, 0, 0, 4096, 0);
        queue_request(REQ_ROTATE, 0, 0, 0, 0, -2, 3);

        // Backward, second position beyond the table; counters still advance
        enter_phase(2, 1, 1, 1, 0, 1);
        queue_request(REQ_ROTATE, 1, 0, 0, 0, -32768, 32767);
        queue_request(REQ_ROTATE, 0, 0, 0, 0, 100, 200);
        queue_request(REQ_ROTATE, 0, 0, 0, 0, 32767, -32768);
        queue_request(REQ_ROTATE, 0, 0, 0, 0, 5, 5);
        enter_phase(2, 1, 1, 0, 0, 1);
        queue_request(REQ_ROTATE, 1, 0, 0, 0, 1234, -1234);

        requests_queued = 0;
        enter_phase(1, 1, 128, 128, 127, 0);
        run_rotations(1'b1);
        enter_phase(8191, 127, 255, 8191, 127, 1);
        run_rotations(1'b0);
        enter_phase(0, 0, 0, 0, 0, 0);
        run_rotations(1'b0);
        enter_phase(4096, 64, 128, 4096, 4095, 1);
        run_rotations(1'b0);
        enter_phase(4096, 1, 1, 4096, 4095, 0);
        run_rotations(1'b0);
        while (requests_queued < RANDOM_ITEMS)
        begin
            do
            begin
                sl  = pick_geometry(8, 4096, 8191);
                hc  = pick_geometry(4, 64, 127);
                pph = pick_geometry(8, 128, 255);
                tp  = pick_geometry(16, 4096, 8191);
                case ($urandom_range(0, 9))
                    0: off = 4095;
                    1: off = $urandom_range(0, 4095);
                    default: off = $urandom_range(0, 8);
                endcase
                bwd = $urandom_range(0, 1);
                collect_reachable(sl, pph, tp, off);
            end
            while (reach_list.size() > 96);
            enter_phase(sl, hc, pph, tp, off, bwd);
            run_rotations($urandom_range(0, 3) == 0);
        end

        wait_drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
